/* rtl/icc_pkg.sv */
package icc_pkg;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_REQ   = 2'd2,
    ACT_ACK   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    PH_ICW1 = 3'd0,
    PH_ICW2 = 3'd1,
    PH_ICW3 = 3'd2,
    PH_ICW4 = 3'd3,
    PH_RUN  = 3'd4
  } phase_t;

  localparam logic [7:0] ICW1_FLAG     = 8'h10;
  localparam logic [7:0] KIND_MASK     = 8'h18;
  localparam logic [7:0] KIND_OCW2     = 8'h00;
  localparam logic [7:0] OCW2_CMD_MASK = 8'hE0;
  localparam logic [7:0] OCW2_EOI      = 8'h20;
  localparam logic [7:0] OCW2_SEOI     = 8'h60;
  localparam logic [7:0] BASE_MASK     = 8'hF8;
  localparam logic [7:0] MASK_ALL      = 8'hFF;
  localparam logic [2:0] SPURIOUS_LINE = 3'd7;

  typedef struct packed {
    action_t    action;
    logic       reg_select;
    logic [7:0] data_byte;
    logic [2:0] irq_line;
  } item_t;

  typedef struct packed {
    logic [7:0] bus_data;
    logic       bus_driven;
    logic       int_request;
  } result_t;

  // Lowest set bit index; bit 3 set means no bit set.
  function automatic logic [3:0] top_line(input logic [7:0] b);
    logic [3:0] n;
    n = 4'd8;
    for (int i = 7; i >= 0; i--) begin
      if (b[i]) n = 4'(i);
    end
    return n;
  endfunction

  // INT is high when the best unmasked request outranks all in service.
  function automatic logic int_calc(input logic [7:0] req, input logic [7:0] mask,
                                    input logic [7:0] serv);
    logic [7:0] pend;
    pend = req & ~mask;
    return (pend != 8'h00) && (top_line(pend) < top_line(serv));
  endfunction

endpackage

/* rtl/icc_if.sv */
interface icc_evt_if;
  logic                valid;
  logic                ready;
  icc_pkg::action_t    action;
  logic                reg_select;
  logic [7:0]          data_byte;
  logic [2:0]          irq_line;

  modport source (output valid, action, reg_select, data_byte, irq_line, input ready);
  modport sink   (input valid, action, reg_select, data_byte, irq_line, output ready);
endinterface

interface icc_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] bus_data;
  logic       bus_driven;
  logic       int_request;

  modport source (output valid, bus_data, bus_driven, int_request, input ready);
  modport sink   (input valid, bus_data, bus_driven, int_request, output ready);
endinterface

/* rtl/icc_engine.sv */
module icc_engine (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  icc_pkg::item_t   item,
  output icc_pkg::result_t res
);

  icc_pkg::phase_t phase, phase_next;
  logic       single_mode, single_mode_next;
  logic       fourth_word, fourth_word_next;
  logic [7:0] vec_base, vec_base_next;
  logic [7:0] mask_bits, mask_bits_next;
  logic [7:0] request_bits, request_bits_next;
  logic [7:0] service_bits, service_bits_next;
  logic       read_sel, read_sel_next;
  logic       int_level, int_level_next;

  logic [7:0] pend;
  logic [3:0] ack_line;
  logic [3:0] eoi_line;
  icc_pkg::phase_t after_third;

  assign pend        = request_bits & ~mask_bits;
  assign ack_line    = icc_pkg::top_line(pend);
  assign eoi_line    = icc_pkg::top_line(service_bits);
  assign after_third = fourth_word ? icc_pkg::PH_ICW4 : icc_pkg::PH_RUN;

  always_comb begin
    phase_next        = phase;
    single_mode_next  = single_mode;
    fourth_word_next  = fourth_word;
    vec_base_next     = vec_base;
    mask_bits_next    = mask_bits;
    request_bits_next = request_bits;
    service_bits_next = service_bits;
    read_sel_next     = read_sel;
    int_level_next    = int_level;
    res               = '0;

    case (item.action)
      icc_pkg::ACT_WRITE: begin
        if (!item.reg_select) begin
          if ((item.data_byte & icc_pkg::ICW1_FLAG) != 8'h00) begin
            single_mode_next  = item.data_byte[1];
            fourth_word_next  = item.data_byte[0];
            mask_bits_next    = icc_pkg::MASK_ALL;
            request_bits_next = 8'h00;
            service_bits_next = 8'h00;
            phase_next        = icc_pkg::PH_ICW2;
            int_level_next    = 1'b0;
          end else if ((item.data_byte & icc_pkg::KIND_MASK) == icc_pkg::KIND_OCW2) begin
            if ((item.data_byte & icc_pkg::OCW2_CMD_MASK) == icc_pkg::OCW2_EOI) begin
              if (!eoi_line[3]) service_bits_next[eoi_line[2:0]] = 1'b0;
            end else if ((item.data_byte & icc_pkg::OCW2_CMD_MASK) == icc_pkg::OCW2_SEOI) begin
              service_bits_next[item.data_byte[2:0]] = 1'b0;
            end
            int_level_next = icc_pkg::int_calc(request_bits, mask_bits, service_bits_next);
          end else begin
            if (item.data_byte[1]) read_sel_next = item.data_byte[0];
          end
        end else begin
          case (phase)
            icc_pkg::PH_ICW2: begin
              vec_base_next = item.data_byte & icc_pkg::BASE_MASK;
              phase_next    = single_mode ? after_third : icc_pkg::PH_ICW3;
            end
            icc_pkg::PH_ICW3: phase_next = after_third;
            icc_pkg::PH_ICW4: phase_next = icc_pkg::PH_RUN;
            default: begin
              mask_bits_next = item.data_byte;
              int_level_next = icc_pkg::int_calc(request_bits, item.data_byte, service_bits);
            end
          endcase
        end
      end
      icc_pkg::ACT_READ: begin
        if (!item.reg_select) res.bus_data = read_sel ? service_bits : request_bits;
        else                  res.bus_data = mask_bits;
        res.bus_driven = 1'b1;
      end
      icc_pkg::ACT_REQ: begin
        request_bits_next[item.irq_line] = 1'b1;
        int_level_next = icc_pkg::int_calc(request_bits_next, mask_bits, service_bits);
      end
      default: begin
        // acknowledge: grant the best pending line, or answer spurious
        if (!ack_line[3]) begin
          service_bits_next[ack_line[2:0]] = 1'b1;
          request_bits_next[ack_line[2:0]] = 1'b0;
          res.bus_data   = vec_base + {5'd0, ack_line[2:0]};
          int_level_next = 1'b0;
        end else begin
          res.bus_data = vec_base + {5'd0, icc_pkg::SPURIOUS_LINE};
        end
        res.bus_driven = 1'b1;
      end
    endcase

    res.int_request = int_level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= icc_pkg::PH_ICW1;
      single_mode  <= 1'b0;
      fourth_word  <= 1'b0;
      vec_base     <= 8'h00;
      mask_bits    <= icc_pkg::MASK_ALL;
      request_bits <= 8'h00;
      service_bits <= 8'h00;
      read_sel     <= 1'b0;
      int_level    <= 1'b0;
    end else if (fire) begin
      phase        <= phase_next;
      single_mode  <= single_mode_next;
      fourth_word  <= fourth_word_next;
      vec_base     <= vec_base_next;
      mask_bits    <= mask_bits_next;
      request_bits <= request_bits_next;
      service_bits <= service_bits_next;
      read_sel     <= read_sel_next;
      int_level    <= int_level_next;
    end
  end

  a_icw1_clears: assert property (@(posedge clk) disable iff (rst)
    fire && item.action == icc_pkg::ACT_WRITE && !item.reg_select && item.data_byte[4]
    |=> mask_bits == icc_pkg::MASK_ALL && request_bits == 8'h00 && service_bits == 8'h00
        && phase == icc_pkg::PH_ICW2 && !int_level)
    else $error("init word did not clear state");

  a_grant: assert property (@(posedge clk) disable iff (rst)
    fire && item.action == icc_pkg::ACT_ACK && pend != 8'h00
    |=> !int_level && service_bits[$past(ack_line[2:0])]
        && !request_bits[$past(ack_line[2:0])])
    else $error("acknowledge did not grant the best pending line");

  a_read_keeps: assert property (@(posedge clk) disable iff (rst)
    fire && item.action == icc_pkg::ACT_READ
    |=> $stable(request_bits) && $stable(service_bits) && $stable(mask_bits)
        && $stable(int_level))
    else $error("read changed state");

  a_idle_keeps: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(request_bits) && $stable(service_bits) && $stable(mask_bits)
              && $stable(phase))
    else $error("state changed without a transfer");

endmodule

/* rtl/interrupt_controller_8_line.sv */
// Eight-line interrupt controller core, single-master mode.
//
// Channels: evt carries one event per transfer (bus write, bus read,
// request line rising edge, acknowledge falling edge); rsp returns one
// result per event: the byte driven on the data bus, whether it is
// driven, and the INT level after the event. Both channels transfer on a
// rising clock edge with valid and ready high.
//
// Flow: an event taken into the event register is processed when the
// result register is free, and its result is offered on rsp from then on.
// Throughput: one event per cycle while rsp is not held; state update and
// the 8-bit priority encoders sit in one stage between the event register
// and the result register.
//
// Reset (rst, synchronous, active high): init phase awaits the first init
// word, mask all ones, requests and in-service cleared, INT low, both
// stages empty.
//
// Stall: while rsp is held, the pending result stays put and one more
// event is taken into the event register; then evt.ready drops.
module interrupt_controller_8_line_core (
  input  logic         clk,
  input  logic         rst,
  icc_evt_if.sink      evt,
  icc_rsp_if.source    rsp
);

  icc_pkg::item_t   item_q;
  logic             item_valid;
  icc_pkg::result_t res;
  icc_pkg::result_t res_q;
  logic             res_valid;
  logic             advance;
  logic             take;

  // Advance the held event into the result register when that is free.
  assign advance   = item_valid && (!res_valid || rsp.ready);
  assign evt.ready = !item_valid || advance;
  assign take      = evt.valid && evt.ready;

  // Event register: load on transfer, drop once processed.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (take) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_q.action     <= evt.action;
      item_q.reg_select <= evt.reg_select;
      item_q.data_byte  <= evt.data_byte;
      item_q.irq_line   <= evt.irq_line;
    end
  end

  icc_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .item (item_q),
    .res  (res)
  );

  // Result register: hold until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (rsp.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) res_q <= res;
  end

  assign rsp.valid       = res_valid;
  assign rsp.bus_data    = res_q.bus_data;
  assign rsp.bus_driven  = res_q.bus_driven;
  assign rsp.int_request = res_q.int_request;

endmodule
